>>> src/lavt_pkg.sv
// Shared types and constants of the look-at view transform.
package lavt_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int NUM_REGS = 6;

  localparam logic [2:0] REG_CAM_POS_X = 3'd0;
  localparam logic [2:0] REG_CAM_POS_Y = 3'd1;
  localparam logic [2:0] REG_CAM_POS_Z = 3'd2;
  localparam logic [2:0] REG_LOOK_X    = 3'd3;
  localparam logic [2:0] REG_LOOK_Y    = 3'd4;
  localparam logic [2:0] REG_LOOK_Z    = 3'd5;

  localparam logic signed [DATA_W-1:0] LOOK_Z_RESET = 32'sd65536;

  typedef enum logic [2:0] {
    ST_LOAD_D,
    ST_LOAD_C,
    ST_SHIFT,
    ST_SQUARE,
    ST_SQRT,
    ST_DIVIDE,
    ST_CROSS,
    ST_DONE
  } bstate_t;

endpackage

>>> src/lavt_basis.sv
// Sequential engine that builds the camera basis from the position and target.
module lavt_basis import lavt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [DATA_W-1:0]        pos [3],
  input  logic signed [DATA_W-1:0]        look [3],
  output logic                            done,
  output logic signed [FRAC_BITS+2:0]     fwd [3],
  output logic signed [FRAC_BITS+2:0]     rgt [3],
  output logic signed [FRAC_BITS+2:0]     upv [3]
);

  localparam int VW = FRAC_BITS + 3;
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam int QW = FRAC_BITS + 2;
  localparam int AW = 2 * VW;

  bstate_t state, state_next;

  logic [1:0]          idx;
  logic [CW-1:0]       cnt;
  logic [32:0]         a [3];
  logic                neg [3];
  logic [63:0]         sumsq;
  logic [63:0]         rad;
  logic [63:0]         root;
  logic [63:0]         bitm;
  logic [NW-1:0]       num;
  logic [33:0]         rem;
  logic [QW-1:0]       quo;
  logic signed [AW-1:0] acc;
  logic                pass_c;

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    abs33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [NW-1:0] num_load(input logic [32:0] av, input logic [63:0] mv);
    num_load = (NW'(av[30:0]) << FRAC_BITS) + NW'(mv[31:1]);
  endfunction

  // Source vectors of the two normalize passes.
  logic signed [32:0] dv [3];
  logic signed [32:0] cv [3];
  logic               d_zero, c_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i] = 33'({look[i][DATA_W-1], look[i]}) - 33'({pos[i][DATA_W-1], pos[i]});
    end
    cv[0] = 33'(-fwd[2]);
    cv[1] = '0;
    cv[2] = 33'(fwd[0]);
    d_zero = (dv[0] == '0) && (dv[1] == '0) && (dv[2] == '0);
    c_zero = (cv[0] == '0) && (cv[2] == '0);
  end

  logic [32:0] m;
  always_comb begin
    m = a[0];
    if (a[1] > m) m = a[1];
    if (a[2] > m) m = a[2];
  end

  // Square root step.
  logic [63:0] trial, rad_n, root_n;
  logic        sq_ge;
  always_comb begin
    trial = root + bitm;
    sq_ge = rad >= trial;
    rad_n = sq_ge ? rad - trial : rad;
    root_n = sq_ge ? (root >> 1) + bitm : root >> 1;
  end

  logic [61:0] sq;
  assign sq = a[idx][30:0] * a[idx][30:0];

  // Restoring division step.
  logic [33:0]         rem_sh, rem_n;
  logic                dv_ge;
  logic [QW-1:0]       q_fin;
  logic signed [VW-1:0] comp;
  always_comb begin
    rem_sh = {rem[32:0], num[NW-1]};
    dv_ge = rem_sh >= {2'b00, root[31:0]};
    rem_n = dv_ge ? rem_sh - {2'b00, root[31:0]} : rem_sh;
    q_fin = {quo[QW-2:0], dv_ge};
    comp = neg[idx] ? -VW'(q_fin) : VW'(q_fin);
  end

  // Cross product step for the new up axis.
  logic signed [VW-1:0] opa, opb;
  logic signed [AW-1:0] prod, diff;
  always_comb begin
    case (cnt[2:0])
      3'd0: begin opa = rgt[1]; opb = fwd[2]; end
      3'd1: begin opa = rgt[2]; opb = fwd[1]; end
      3'd2: begin opa = rgt[2]; opb = fwd[0]; end
      3'd3: begin opa = rgt[0]; opb = fwd[2]; end
      3'd4: begin opa = rgt[0]; opb = fwd[1]; end
      default: begin opa = rgt[1]; opb = fwd[0]; end
    endcase
    prod = opa * opb;
    diff = acc - prod + (AW'(1) <<< (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD_D;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD_D: state_next = d_zero ? ST_LOAD_C : ST_SHIFT;
      ST_LOAD_C: state_next = c_zero ? ST_CROSS : ST_SHIFT;
      ST_SHIFT: begin
        if (m[32:31] == 2'b00 && m[30]) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (idx == 2'd2) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt == CW'(31)) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (cnt == CW'(NW - 1) && idx == 2'd2) state_next = pass_c ? ST_CROSS : ST_LOAD_C;
      end
      ST_CROSS: begin
        if (cnt[2:0] == 3'd5) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_DONE;
      default: state_next = ST_LOAD_D;
    endcase
    if (start) state_next = ST_LOAD_D;
  end

  assign done = (state == ST_DONE);

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD_D: begin
        pass_c <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          a[i] <= abs33(dv[i]);
          neg[i] <= dv[i][32];
          if (d_zero) fwd[i] <= '0;
        end
      end
      ST_LOAD_C: begin
        pass_c <= 1'b1;
        cnt <= '0;
        acc <= '0;
        for (int i = 0; i < 3; i++) begin
          a[i] <= abs33(cv[i]);
          neg[i] <= cv[i][32];
          if (c_zero) rgt[i] <= '0;
        end
      end
      ST_SHIFT: begin
        idx <= '0;
        sumsq <= '0;
        for (int i = 0; i < 3; i++) begin
          if (m[32:31] != 2'b00) a[i] <= a[i] >> 1;
          else if (!m[30]) a[i] <= a[i] << 1;
        end
      end
      ST_SQUARE: begin
        sumsq <= sumsq + 64'(sq);
        idx <= idx + 2'd1;
        if (idx == 2'd2) begin
          rad <= sumsq + 64'(sq);
          root <= '0;
          bitm <= 64'd1 << 62;
          cnt <= '0;
        end
      end
      ST_SQRT: begin
        rad <= rad_n;
        root <= root_n;
        bitm <= bitm >> 2;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(31)) begin
          cnt <= '0;
          idx <= '0;
          num <= num_load(a[0], root_n);
          rem <= '0;
          quo <= '0;
        end
      end
      ST_DIVIDE: begin
        num <= num << 1;
        rem <= rem_n;
        quo <= q_fin;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          if (pass_c) rgt[idx] <= comp;
          else fwd[idx] <= comp;
          cnt <= '0;
          rem <= '0;
          quo <= '0;
          if (idx != 2'd2) begin
            idx <= idx + 2'd1;
            num <= num_load(a[idx + 2'd1], root);
          end
        end
      end
      ST_CROSS: begin
        cnt <= cnt + CW'(1);
        if (cnt[0]) upv[cnt[2:1]] <= VW'(diff >>> FRAC_BITS);
        else acc <= prod;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

>>> src/look_at_view_transform_top.sv
// Top level of the look-at view transform: APB registers, basis engine, dot pipeline.
// A point transfer passes the t, prod, acc and view registers on its way to the output.
// Throughput: one point per cycle; the four-stage dot pipeline stalls as a whole.
// After reset or any register write the basis engine rebuilds the camera frame,
// and in_ready stays low until the rebuild ends.
// Reset is synchronous and active high; registers return to position 0, target (0,0,1).
module look_at_view_transform_top import lavt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] point_x,
  input  logic signed [DATA_W-1:0] point_y,
  input  logic signed [DATA_W-1:0] point_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] view_x,
  output logic signed [DATA_W-1:0] view_y,
  output logic signed [DATA_W-1:0] view_z
);

  localparam int VW = FRAC_BITS + 3;
  localparam int PW = 33 + VW;
  localparam int SW = PW + 2;

  // Configuration registers. A write restarts the basis engine.
  logic signed [DATA_W-1:0] pos [3];
  logic signed [DATA_W-1:0] look [3];
  logic                     wr_en;
  logic [2:0]               wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0]  <= '0;
      pos[1]  <= '0;
      pos[2]  <= '0;
      look[0] <= '0;
      look[1] <= '0;
      look[2] <= LOOK_Z_RESET;
    end else if (wr_en) begin
      case (wr_idx)
        REG_CAM_POS_X: pos[0]  <= pwdata;
        REG_CAM_POS_Y: pos[1]  <= pwdata;
        REG_CAM_POS_Z: pos[2]  <= pwdata;
        REG_LOOK_X:    look[0] <= pwdata;
        REG_LOOK_Y:    look[1] <= pwdata;
        REG_LOOK_Z:    look[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_CAM_POS_X: prdata = pos[0];
      REG_CAM_POS_Y: prdata = pos[1];
      REG_CAM_POS_Z: prdata = pos[2];
      REG_LOOK_X:    prdata = look[0];
      REG_LOOK_Y:    prdata = look[1];
      REG_LOOK_Z:    prdata = look[2];
      default:       prdata = '0;
    endcase
  end

  // The basis depends only on the registers, so it is built once per change.
  logic                 basis_done;
  logic signed [VW-1:0] fwd [3];
  logic signed [VW-1:0] rgt [3];
  logic signed [VW-1:0] upv [3];

  lavt_basis #(.FRAC_BITS(FRAC_BITS)) u_basis (
    .clk   (clk),
    .rst   (rst),
    .start (wr_en),
    .pos   (pos),
    .look  (look),
    .done  (basis_done),
    .fwd   (fwd),
    .rgt   (rgt),
    .upv   (upv)
  );

  // Dot pipeline. Every stage advances when the output register is free or
  // its transfer completes, so a stall freezes the whole pipe intact.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && basis_done;

  logic signed [VW-1:0] bas [3][3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      bas[0][j] = rgt[j];
      bas[1][j] = upv[j];
      bas[2][j] = fwd[j];
    end
  end

  logic                 v1, v2, v3;
  logic signed [32:0]   t [3];
  logic signed [PW-1:0] prod [3][3];
  logic signed [SW-1:0] acc [3];
  logic signed [DATA_W-1:0] pt [3];
  logic signed [SW-1:0] sh [3];
  logic signed [DATA_W-1:0] sat [3];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = acc[i] >>> FRAC_BITS;
      if (sh[i][SW-1:DATA_W-1] == '0 || sh[i][SW-1:DATA_W-1] == '1) begin
        sat[i] = sh[i][DATA_W-1:0];
      end else begin
        sat[i] = sh[i][SW-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && in_ready;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        t[j] <= 33'({pt[j][DATA_W-1], pt[j]}) - 33'({pos[j][DATA_W-1], pos[j]});
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PW'(t[j]) * PW'(bas[i][j]);
        end
        acc[i] <= SW'(prod[i][0]) + SW'(prod[i][1]) + SW'(prod[i][2])
                  + (SW'(1) <<< (FRAC_BITS - 1));
      end
      view_x <= sat[0];
      view_y <= sat[1];
      view_z <= sat[2];
    end
  end

endmodule

>>> src/lavt_checker.sv
// Port-level checker for the look-at view transform, bound to the top level.
module lavt_checker import lavt_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic                     pready,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] view_x,
  input logic signed [DATA_W-1:0] view_y,
  input logic signed [DATA_W-1:0] view_z
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(view_x) && $stable(view_y)
    && $stable(view_z))
    else $error("stalled result changed");

  // Reset empties the pipe and starts a basis rebuild.
  assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

  // A register write restarts the basis, which blocks new points.
  assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready |=> !in_ready)
    else $error("point accepted during basis rebuild");

  // Input is only taken when the output side can move.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken while pipe is stalled");

endmodule

bind look_at_view_transform_top lavt_checker u_lavt_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the look-at view transform top level.
`timescale 1ns / 1ps

module tb_top;
  import lavt_pkg::*;

  localparam int FRAC = 16;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  // Configuration port.
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Point and view channels.
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] point_x = '0;
  logic signed [DATA_W-1:0] point_y = '0;
  logic signed [DATA_W-1:0] point_z = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] view_x;
  logic signed [DATA_W-1:0] view_y;
  logic signed [DATA_W-1:0] view_z;

  look_at_view_transform_top #(.FRAC_BITS(FRAC)) uut (.*);

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } view_t;

  // The testbench's own copy of the camera registers, and the views still awaited.
  logic signed [31:0] cam_regs [NUM_REGS];
  view_t              pending_views [$];
  int                 fail_count = 0;
  int                 hold_cycles = 0;
  int                 rx_wait = 0;

  // Fixed-point helpers, built from the documented arithmetic.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (FRAC - 1));
    return t >>> FRAC;  // arithmetic shift floors, which is round half up overall
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vector(input logic signed [63:0] v [3],
                                      output logic signed [63:0] r [3]);
    logic [63:0] a [3];
    logic [63:0] m;
    logic [63:0] sum;
    logic [63:0] len_mag;
    logic [63:0] q;
    int len;
    m = 0;
    sum = 0;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = v[i] < 0 ? -v[i] : v[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) r[i] = 0;
      return;
    end
    while (len < 64 && (m >> len) != 0) len++;
    for (int i = 0; i < 3; i++) begin
      if (len > 31) a[i] = a[i] >> (len - 31);
      else a[i] = a[i] << (31 - len);
      sum += a[i] * a[i];
    end
    len_mag = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FRAC) + len_mag / 2) / len_mag;
      r[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic logic signed [31:0] sat_dot(input logic signed [63:0] t [3],
                                                 input logic signed [63:0] b [3]);
    logic signed [63:0] s;
    s = round_shift(t[0] * b[0] + t[1] * b[1] + t[2] * b[2]);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // Builds the camera basis from the register copy and projects one point onto it.
  function automatic view_t camera_view(input logic signed [31:0] px,
                                        input logic signed [31:0] py,
                                        input logic signed [31:0] pz);
    logic signed [63:0] pos [3];
    logic signed [63:0] d [3];
    logic signed [63:0] fwd [3];
    logic signed [63:0] c [3];
    logic signed [63:0] rgt [3];
    logic signed [63:0] upv [3];
    logic signed [63:0] t [3];
    logic signed [63:0] one;
    view_t res;
    one = 64'sd1 <<< FRAC;
    for (int i = 0; i < 3; i++) begin
      pos[i] = cam_regs[i];
      d[i] = 64'(cam_regs[3 + i]) - pos[i];
    end
    unit_vector(d, fwd);
    // Forward crossed with the world up (0, 1, 0).
    c[0] = round_shift(-fwd[2] * one);
    c[1] = 0;
    c[2] = round_shift(fwd[0] * one);
    unit_vector(c, rgt);
    upv[0] = round_shift(rgt[1] * fwd[2] - rgt[2] * fwd[1]);
    upv[1] = round_shift(rgt[2] * fwd[0] - rgt[0] * fwd[2]);
    upv[2] = round_shift(rgt[0] * fwd[1] - rgt[1] * fwd[0]);
    t[0] = 64'(px) - pos[0];
    t[1] = 64'(py) - pos[1];
    t[2] = 64'(pz) - pos[2];
    res.vx = sat_dot(t, rgt);
    res.vy = sat_dot(t, upv);
    res.vz = sat_dot(t, fwd);
    return res;
  endfunction

  // Writes one register through a setup phase and an access phase, then returns the bus to idle.
  task automatic write_reg(input logic [2:0] idx, input logic signed [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cam_regs[idx] = val;
    @(posedge clk);
  endtask

  // Waits until every awaited view has arrived, plus the pipeline latency.
  task automatic drain;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_camera(input logic signed [31:0] v [6]);
    drain();
    write_reg(REG_CAM_POS_X, v[0]);
    write_reg(REG_CAM_POS_Y, v[1]);
    write_reg(REG_CAM_POS_Z, v[2]);
    write_reg(REG_LOOK_X, v[3]);
    write_reg(REG_LOOK_Y, v[4]);
    write_reg(REG_LOOK_Z, v[5]);
  endtask

  // Sends one point after a random gap; the view is predicted at the transfer.
  task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] pz, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_views.push_back(camera_view(px, py, pz));
  endtask

  task automatic end_burst;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord;
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sd524288;
      3: return 32'($urandom_range(0, 10)) <<< FRAC;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_points(input int n);
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    end_burst();
  endtask

  // Receiver: after each view transfer it may hold out_ready low for a randomly drawn wait before
  // taking the next one, with an occasional long hold-off set by the tests.
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = $urandom_range(0, 4);
      rx_wait <= w;
      out_ready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checks each view transfer against the oldest prediction.
  always @(posedge clk) begin
    view_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        $error("view transfer with nothing awaited: %0d %0d %0d", view_x, view_y, view_z);
        fail_count++;
      end else begin
        want = pending_views.pop_front();
        if (view_x !== want.vx) begin
          $error("view_x expected %0d actual %0d", want.vx, view_x);
          fail_count++;
        end
        if (view_y !== want.vy) begin
          $error("view_y expected %0d actual %0d", want.vy, view_y);
          fail_count++;
        end
        if (view_z !== want.vz) begin
          $error("view_z expected %0d actual %0d", want.vz, view_z);
          fail_count++;
        end
      end
    end
  end

  // Default camera after reset: at the origin, looking down +z.
  task automatic test_reset_camera;
    send_point(0, 0, 0);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh00010000);
    send_point(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
    send_point(32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0);
    end_burst();
  endtask

  // Target equal to the position: all outputs are zero.
  task automatic test_degenerate_target;
    logic signed [31:0] v [6];
    v = '{32'sh00030000, -32'sh00020000, 32'sh00010000,
          32'sh00030000, -32'sh00020000, 32'sh00010000};
    set_camera(v);
    send_point(32'sh12345678, 32'sh7fffffff, 32'sh80000000);
    send_point(0, 0, 0);
    end_burst();
  endtask

  // Looking straight up, then straight down: right and up vanish.
  task automatic test_vertical_view;
    logic signed [31:0] v [6];
    v = '{0, 0, 0, 0, 32'sh00050000, 0};
    set_camera(v);
    send_point(32'sh00010000, 32'sh00070000, -32'sh00030000);
    end_burst();
    v = '{0, 32'sh7fffffff, 0, 0, 32'sh80000000, 0};
    set_camera(v);
    send_point(32'sh00010000, 32'sh80000000, 32'sh7fffffff);
    end_burst();
  endtask

  // Extreme registers, so that differences span 33 bits and dots saturate.
  task automatic test_extreme_camera;
    logic signed [31:0] v [6];
    v = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    set_camera(v);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    end_burst();
    v = '{32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000, 0, 32'sh80000001};
    set_camera(v);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_point(1, -1, 1);
    end_burst();
  endtask

  // The receiver stops for a long stretch while points keep coming, so the
  // pipeline fills and in_ready must drop.
  task automatic test_output_backpressure;
    drain();
    hold_cycles = 60;
    for (int i = 0; i < 30; i++) send_point(rand_coord(), rand_coord(), rand_coord(), 1);
    end_burst();
  endtask

  // Random cameras with random points, each camera followed by a burst.
  task automatic test_random_cameras;
    logic signed [31:0] v [6];
    for (int k = 0; k < 28; k++) begin
      for (int i = 0; i < 6; i++) v[i] = rand_coord();
      set_camera(v);
      random_points(50);
    end
  endtask

  initial begin
    cam_regs = '{0, 0, 0, 0, 0, LOOK_Z_RESET};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_camera();
    test_degenerate_target();
    test_vertical_view();
    test_extreme_camera();
    test_output_backpressure();
    test_random_cameras();
    drain();
    if (fail_count == 0) $display("look_at_view_transform_top: match");
    else $display("look_at_view_transform_top: mismatch");
    $finish;
  end

  // Run limit: about 1500 points plus some 35 basis rebuilds stay well within this bound of
  // simulated time, even with every stall.
  initial begin
    #20ms;
    $display("look_at_view_transform_top: mismatch");
    $finish;
  end

endmodule

>>> look_at_view_transform_top.f
src/lavt_pkg.sv
src/lavt_basis.sv
src/look_at_view_transform_top.sv
src/lavt_checker.sv
tb/tb_top.sv
